>>> sv/sbpa_pkg.sv
// ----------------------------------------------------------------------------
// sbpa_pkg
// Shared types, codes and configuration helpers of the segregated block pool
// allocator.
// ----------------------------------------------------------------------------
package sbpa_pkg;

    // Number of subpools that have fields in the configuration registers.
    localparam int POOLS_CFG = 4;

    localparam logic [15:0] FREE_MARK = 16'hFFFF;

    // Operation codes.
    localparam logic [2:0] OP_RESERVE    = 3'd0;
    localparam logic [2:0] OP_DELETE     = 3'd1;
    localparam logic [2:0] OP_LOOKUP     = 3'd2;
    localparam logic [2:0] OP_CLEAR_ALL  = 3'd3;
    localparam logic [2:0] OP_CLEAR_POOL = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ILLEGAL   = 3'd1;
    localparam logic [2:0] ST_NO_DATA   = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SUBPOOLS_USED = 2'd0;
    localparam logic [1:0] CFG_ELEMENT_SIZES = 2'd1;
    localparam logic [1:0] CFG_SLOT_COUNTS   = 2'd2;
    localparam logic [1:0] CFG_SPILL_ENABLE  = 2'd3;

    typedef struct packed {
        logic [2:0]  subpools_used;
        logic [63:0] element_sizes;
        logic [19:0] slot_counts;
        logic        spill_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        CMD_RESERVE,
        CMD_DELETE,
        CMD_LOOKUP,
        CMD_CLEAR_ALL,
        CMD_CLEAR_POOL,
        CMD_ILLEGAL
    } cmd_kind_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] req_size;
        logic [1:0]  pool;
        logic [3:0]  slot;
        logic        suppress;
        logic        in_range;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  pool;
        logic [3:0]  slot;
        logic [15:0] size;
        logic        report;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_READ,
        BK_DONE
    } bk_state_t;

    // Element size of a subpool; subpools without configuration fields have size 0.
    function automatic logic [15:0] pool_elem_size(cfg_t c, logic [3:0] p);
        logic [15:0] sz;
        sz = c.element_sizes[p[1:0]*16 +: 16];
        if (p >= 4'(POOLS_CFG))
        begin
            sz = 16'd0;
        end
        return sz;
    endfunction

    function automatic logic [4:0] pool_slot_raw(cfg_t c, logic [3:0] p);
        logic [4:0] cnt;
        cnt = c.slot_counts[p[1:0]*5 +: 5];
        if (p >= 4'(POOLS_CFG))
        begin
            cnt = 5'd0;
        end
        return cnt;
    endfunction

    function automatic logic [4:0] clamp_count(logic [4:0] raw, logic [8:0] lim);
        return (9'(raw) > lim) ? lim[4:0] : raw;
    endfunction

    function automatic logic [2:0] clamp_used(logic [2:0] raw, logic [4:0] lim);
        return (5'(raw) > lim) ? lim[2:0] : raw;
    endfunction

endpackage

>>> sv/sbpa_ram.sv
// ----------------------------------------------------------------------------
// sbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sbpa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sbpa_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sbpa_cmd_fifo
    import sbpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/sbpa_front.sv
// ----------------------------------------------------------------------------
// sbpa_front
// Front end: accepts request transactions, decodes the operation and checks
// the subpool and slot selection against the configuration.
// ----------------------------------------------------------------------------
module sbpa_front
    import sbpa_pkg::*;
#(
    parameter int SUBPOOLS_MAX = 4,
    parameter int SLOTS_MAX    = 16
) (
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [15:0] req_size,
    input  logic [1:0]  pool_sel,
    input  logic [3:0]  slot_sel,
    input  logic        suppress_report,
    input  cfg_t        cfg,
    input  logic        fifo_full,
    output logic        push,
    output cmd_t        cmd
);

    logic [2:0]  used_eff;
    logic [3:0]  psel_ext;
    logic [15:0] esize;
    logic [4:0]  cnt;
    logic        pool_ok;
    logic        slot_ok;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        used_eff = clamp_used(cfg.subpools_used, 5'(SUBPOOLS_MAX));
        psel_ext = {2'b00, pool_sel};
        esize    = pool_elem_size(cfg, psel_ext);
        cnt      = clamp_count(pool_slot_raw(cfg, psel_ext), 9'(SLOTS_MAX));
        pool_ok  = (3'(pool_sel) < used_eff);
        slot_ok  = (5'(slot_sel) < cnt);

        cmd.req_size = req_size;
        cmd.pool     = pool_sel;
        cmd.slot     = slot_sel;
        cmd.suppress = suppress_report;
        cmd.kind     = CMD_ILLEGAL;
        cmd.in_range = 1'b0;
        case (op)
            OP_RESERVE:
            begin
                cmd.kind     = CMD_RESERVE;
                cmd.in_range = 1'b1;
            end
            OP_DELETE:
            begin
                // A subpool with element size zero has no deletable slots.
                cmd.kind     = CMD_DELETE;
                cmd.in_range = pool_ok && (esize != 16'd0) && slot_ok;
            end
            OP_LOOKUP:
            begin
                cmd.kind     = CMD_LOOKUP;
                cmd.in_range = pool_ok && slot_ok;
            end
            OP_CLEAR_ALL:
            begin
                cmd.kind     = CMD_CLEAR_ALL;
                cmd.in_range = 1'b1;
            end
            OP_CLEAR_POOL:
            begin
                cmd.kind     = CMD_CLEAR_POOL;
                cmd.in_range = pool_ok;
            end
            default:
            begin
                cmd.kind     = CMD_ILLEGAL;
                cmd.in_range = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/sbpa_back.sv
// ----------------------------------------------------------------------------
// sbpa_back
// Back end: executes queued commands against the slot occupancy bitmap and
// the stored-size RAM, and holds the result register.
// ----------------------------------------------------------------------------
module sbpa_back
    import sbpa_pkg::*;
#(
    parameter int SUBPOOLS_MAX = 4,
    parameter int SLOTS_MAX    = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    fifo_empty,
    input  cmd_t    head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int PW    = (SUBPOOLS_MAX > 1) ? $clog2(SUBPOOLS_MAX) : 1;
    localparam int SW    = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
    localparam int DEPTH = SUBPOOLS_MAX * SLOTS_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bk_state_t                             state_reg;
    bk_state_t                             state_next;
    cmd_t                                  cmd_reg;
    cmd_t                                  cmd_next;
    logic [PW-1:0]                         pool_reg;
    logic [PW-1:0]                         pool_next;
    logic                                  found_reg;
    logic                                  found_next;
    result_t                               res_reg;
    result_t                               res_next;
    logic [SUBPOOLS_MAX-1:0][SLOTS_MAX-1:0] occ_reg;
    logic [SUBPOOLS_MAX-1:0][SLOTS_MAX-1:0] occ_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    result_t                               out_res_reg;
    result_t                               out_res_next;

    logic [2:0]    used_eff;
    logic          fits;
    logic          fits_any;
    logic [4:0]    cnt_p;
    logic          hit;
    logic [SW-1:0] hit_slot;
    logic [PW-1:0] head_pool;
    logic [SW-1:0] head_slot;
    logic [PW-1:0] cur_pool;
    logic [SW-1:0] cur_slot;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    sbpa_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd_reg.req_size),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Examination of the subpool under the search pointer.
    always_comb
    begin
        used_eff = clamp_used(cfg.subpools_used, 5'(SUBPOOLS_MAX));
        fits     = (5'(pool_reg) < 5'(used_eff))
                   && (pool_elem_size(cfg, 4'(pool_reg)) >= cmd_reg.req_size)
                   && (cmd_reg.req_size != FREE_MARK);
        cnt_p    = clamp_count(pool_slot_raw(cfg, 4'(pool_reg)), 9'(SLOTS_MAX));
        hit      = 1'b0;
        hit_slot = '0;
        for (int s = SLOTS_MAX - 1; s >= 0; s--)
        begin
            if (!occ_reg[pool_reg][SW'(s)] && (9'(s) < 9'(cnt_p)))
            begin
                hit      = 1'b1;
                hit_slot = SW'(s);
            end
        end
    end

    always_comb
    begin
        head_pool = PW'(head.pool);
        head_slot = SW'(head.slot);
        cur_pool  = PW'(cmd_reg.pool);
        cur_slot  = SW'(cmd_reg.slot);
        fits_any  = found_reg || fits;

        state_next = state_reg;
        cmd_next   = cmd_reg;
        pool_next  = pool_reg;
        found_next = found_reg;
        res_next   = res_reg;
        occ_next   = occ_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = AW'(32'(pool_reg) * SLOTS_MAX + 32'(hit_slot));
        rd_en      = 1'b0;
        rd_addr    = AW'(32'(head_pool) * SLOTS_MAX + 32'(head_slot));

        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop             = 1'b1;
                    cmd_next        = head;
                    res_next        = '0;
                    res_next.status = ST_OK;
                    state_next      = BK_DONE;
                    case (head.kind)
                        CMD_RESERVE:
                        begin
                            pool_next  = '0;
                            found_next = 1'b0;
                            state_next = BK_SEARCH;
                        end
                        CMD_DELETE:
                        begin
                            if (head.in_range)
                            begin
                                occ_next[head_pool][head_slot] = 1'b0;
                            end
                            else
                            begin
                                res_next.status = ST_ILLEGAL;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (head.in_range)
                            begin
                                rd_en      = 1'b1;
                                state_next = BK_READ;
                            end
                            else
                            begin
                                res_next.status = ST_ILLEGAL;
                            end
                        end
                        CMD_CLEAR_ALL:
                        begin
                            occ_next = '0;
                        end
                        CMD_CLEAR_POOL:
                        begin
                            if (head.in_range)
                            begin
                                occ_next[head_pool] = '0;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_ILLEGAL;
                        end
                    endcase
                end
            end
            BK_SEARCH:
            begin
                if (fits && found_reg && !cfg.spill_enable)
                begin
                    // A second fitting subpool without spilling ends the search.
                    res_next.status = ST_FULL;
                    res_next.report = !cmd_reg.suppress;
                    state_next      = BK_DONE;
                end
                else if (fits && hit)
                begin
                    wr_en                        = 1'b1;
                    occ_next[pool_reg][hit_slot] = 1'b1;
                    res_next.pool                = 2'(pool_reg);
                    res_next.slot                = 4'(hit_slot);
                    state_next                   = BK_DONE;
                end
                else
                begin
                    found_next = fits_any;
                    if (pool_reg == PW'(SUBPOOLS_MAX - 1))
                    begin
                        res_next.status = fits_any ? ST_FULL : ST_TOO_LARGE;
                        res_next.report = fits_any && !cmd_reg.suppress;
                        state_next      = BK_DONE;
                    end
                    else
                    begin
                        pool_next = pool_reg + PW'(1);
                    end
                end
            end
            BK_READ:
            begin
                if (occ_reg[cur_pool][cur_slot])
                begin
                    res_next.size = rd_data;
                end
                else
                begin
                    res_next.status = ST_NO_DATA;
                end
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        pool_reg    <= pool_next;
        found_reg   <= found_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

endmodule

>>> sv/segregated_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// segregated_block_pool_allocator
// Slot allocator over up to SUBPOOLS_MAX subpools of SLOTS_MAX slots each.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one result transaction, in order.
// Requests enter a two-entry queue; while a result waits at the output the
// back end can still finish one more command, so up to three requests are
// taken before the input stalls. The back end handles one command at a time:
// a reserve passes through one search state per subpool examined (at most
// SUBPOOLS_MAX), since the search visits one subpool's free bitmap per cycle;
// a lookup passes through a read state because of the registered read of the
// stored-size RAM; delete and both clears go from idle to done. Slot occupancy is
// held in flip-flops cleared at reset and by the clear operations, so no
// clearing pass is needed.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module segregated_block_pool_allocator
    import sbpa_pkg::*;
#(
    parameter int SUBPOOLS_MAX = 4,
    parameter int SLOTS_MAX    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [15:0] req_size,
    input  logic [1:0]  pool_sel,
    input  logic [3:0]  slot_sel,
    input  logic        suppress_report,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [1:0]  pool_out,
    output logic [3:0]  slot_out,
    output logic [15:0] size_out,
    output logic        report_full
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    push;
    cmd_t    push_cmd;
    logic    fifo_full;
    logic    fifo_empty;
    logic    pop;
    cmd_t    head;
    result_t out_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SUBPOOLS_USED: cfg_next.subpools_used = cfg_data[2:0];
                CFG_ELEMENT_SIZES: cfg_next.element_sizes = cfg_data;
                CFG_SLOT_COUNTS:   cfg_next.slot_counts   = cfg_data[19:0];
                CFG_SPILL_ENABLE:  cfg_next.spill_enable  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.subpools_used <= 3'd1;
            cfg_reg.element_sizes <= 64'd0;
            cfg_reg.slot_counts   <= 20'd0;
            cfg_reg.spill_enable  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbpa_front #(
        .SUBPOOLS_MAX (SUBPOOLS_MAX),
        .SLOTS_MAX    (SLOTS_MAX)
    ) u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .req_size        (req_size),
        .pool_sel        (pool_sel),
        .slot_sel        (slot_sel),
        .suppress_report (suppress_report),
        .cfg             (cfg_reg),
        .fifo_full       (fifo_full),
        .push            (push),
        .cmd             (push_cmd)
    );

    sbpa_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty)
    );

    sbpa_back #(
        .SUBPOOLS_MAX (SUBPOOLS_MAX),
        .SLOTS_MAX    (SLOTS_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    assign status      = out_res.status;
    assign pool_out    = out_res.pool;
    assign slot_out    = out_res.slot;
    assign size_out    = out_res.size;
    assign report_full = out_res.report;

endmodule

>>> sv/sbpa_checker.sv
// ----------------------------------------------------------------------------
// sbpa_checker
// Port-level checks on the result channel of the allocator.
// ----------------------------------------------------------------------------
module sbpa_checker
    import sbpa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [1:0]  pool_out,
    input logic [3:0]  slot_out,
    input logic [15:0] size_out,
    input logic        report_full
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pool_out)
            && $stable(slot_out) && $stable(size_out) && $stable(report_full))
        else $error("result changed while stalled");

    // The full report only accompanies a full status.
    a_report_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_full |-> status == ST_FULL)
        else $error("report_full without full status");

    // A failed operation carries no subpool, slot or size.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> pool_out == 2'd0 && slot_out == 4'd0
            && size_out == 16'd0)
        else $error("failed result carries data");

    // A stored size is never the free mark.
    a_size_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> size_out != FREE_MARK)
        else $error("free mark returned as a size");

endmodule

bind segregated_block_pool_allocator sbpa_checker u_sbpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pool_out    (pool_out),
    .slot_out    (slot_out),
    .size_out    (size_out),
    .report_full (report_full)
);

>>> tb/sv/tb_segregated_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_segregated_block_pool_allocator
// Self-checking bench for the segregated block pool allocator. Commands are
// queued per configuration phase and sent in random bursts. A clocked model of
// the slot bookkeeping predicts each result when its request transaction is
// accepted, and a monitor with its own stall pattern compares every result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_segregated_block_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpa_pkg::*;

    localparam int POOLS       = 4;
    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] req_size;
        logic [1:0]  pool;
        logic [3:0]  slot;
        logic        quiet;
    } alloc_cmd_t;

    localparam int CMD_BITS = $bits(alloc_cmd_t);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SUBPOOLS_USED;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = OP_RESERVE;
    logic [15:0] req_size = '0;
    logic [1:0]  pool_sel = '0;
    logic [3:0]  slot_sel = '0;
    logic        suppress_report = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [1:0]  pool_out;
    logic [3:0]  slot_out;
    logic [15:0] size_out;
    logic        report_full;

    // Model copy of the configuration and of the stored-size words.
    logic [2:0]  m_used = 3'd1;
    logic [63:0] m_sizes = '0;
    logic [19:0] m_counts = '0;
    logic        m_spill = 1'b0;
    logic [15:0] slot_word [POOLS*SLOTS];

    alloc_cmd_t cmd_queue [$];
    result_t    expected_results [$];
    alloc_cmd_t cur_cmd = '0;
    alloc_cmd_t next_cmd;
    result_t    want;

    int   burst_left = 0;
    int   gap_left = 0;
    logic sender_pause = 1'b0;
    logic long_hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;
    logic [7:0] stall_pat = 8'hFF;
    logic [5:0] pat_age = '0;
    int   mismatch_count = 0;
    int   results_seen = 0;
    int   cycle_count = 0;

    segregated_block_pool_allocator DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .req_size        (req_size),
        .pool_sel        (pool_sel),
        .slot_sel        (slot_sel),
        .suppress_report (suppress_report),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .pool_out        (pool_out),
        .slot_out        (slot_out),
        .size_out        (size_out),
        .report_full     (report_full)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] elem_bytes(int p);
        return m_sizes[p*16 +: 16];
    endfunction

    function automatic int slot_limit(int p);
        int c;
        c = int'(m_counts[p*5 +: 5]);
        return (c > SLOTS) ? SLOTS : c;
    endfunction

    // Applies one command to the model state and returns the result it gives.
    function automatic result_t pool_step(alloc_cmd_t c);
        result_t r;
        int      n_used;
        int      p;
        int      s;
        bit      fit_found;
        bit      done;
        bit      stop;
        r = '0;
        r.status = ST_OK;
        fit_found = 1'b0;
        done = 1'b0;
        stop = 1'b0;
        n_used = (m_used > 3'd4) ? POOLS : int'(m_used);
        case (c.op)
            OP_RESERVE:
            begin
                if (c.req_size != FREE_MARK)
                begin
                    for (p = 0; p < n_used; p++)
                    begin
                        if (!done && !stop && elem_bytes(p) >= c.req_size)
                        begin
                            // Without spilling only the first fitting subpool is tried.
                            if (fit_found && !m_spill)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                fit_found = 1'b1;
                                for (s = 0; s < SLOTS; s++)
                                begin
                                    if (!done && s < slot_limit(p)
                                        && slot_word[p*SLOTS+s] == FREE_MARK)
                                    begin
                                        slot_word[p*SLOTS+s] = c.req_size;
                                        r.pool = p[1:0];
                                        r.slot = s[3:0];
                                        done = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                if (!done)
                begin
                    if (!fit_found)
                    begin
                        r.status = ST_TOO_LARGE;
                    end
                    else
                    begin
                        r.status = ST_FULL;
                        r.report = ~c.quiet;
                    end
                end
            end
            OP_DELETE:
            begin
                if (int'(c.pool) < n_used && elem_bytes(c.pool) != 16'd0
                    && int'(c.slot) < slot_limit(c.pool))
                begin
                    slot_word[c.pool*SLOTS+c.slot] = FREE_MARK;
                end
                else
                begin
                    r.status = ST_ILLEGAL;
                end
            end
            OP_LOOKUP:
            begin
                if (int'(c.pool) < n_used && int'(c.slot) < slot_limit(c.pool))
                begin
                    if (slot_word[c.pool*SLOTS+c.slot] == FREE_MARK)
                    begin
                        r.status = ST_NO_DATA;
                    end
                    else
                    begin
                        r.size = slot_word[c.pool*SLOTS+c.slot];
                    end
                end
                else
                begin
                    r.status = ST_ILLEGAL;
                end
            end
            OP_CLEAR_ALL:
            begin
                for (s = 0; s < POOLS*SLOTS; s++)
                begin
                    slot_word[s] = FREE_MARK;
                end
            end
            OP_CLEAR_POOL:
            begin
                if (int'(c.pool) < n_used)
                begin
                    for (s = 0; s < SLOTS; s++)
                    begin
                        slot_word[c.pool*SLOTS+s] = FREE_MARK;
                    end
                end
            end
            default:
            begin
                r.status = ST_ILLEGAL;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] exp_val);
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, results_seen, field, got, exp_val);
        mismatch_count++;
    endtask

    task automatic queue_cmd(logic [2:0] o, logic [15:0] req, logic [1:0] p,
                             logic [3:0] s, logic q);
        alloc_cmd_t c;
        c.op = o;
        c.req_size = req;
        c.pool = p;
        c.slot = s;
        c.quiet = q;
        cmd_queue.push_back(c);
    endtask

    // Mostly well-formed commands aimed at the configured sizes and slot
    // counts, with a share of illegal codes and fully random noise.
    task automatic queue_random_cmds(int n);
        alloc_cmd_t c;
        int         k;
        int         sel;
        int         p;
        int         t;
        for (k = 0; k < n; k++)
        begin
            c = alloc_cmd_t'(CMD_BITS'({$urandom, $urandom}));
            c.quiet = ($urandom_range(0, 3) == 0);
            p = $urandom_range(0, POOLS-1);
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                c.op = OP_RESERVE;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        t = int'(elem_bytes(p)) - int'($urandom_range(0, 3));
                        c.req_size = (t < 0) ? 16'd0 : t[15:0];
                    end
                    6: c.req_size = elem_bytes(p) + 16'd1;
                    7: c.req_size = 16'($urandom);
                    8: c.req_size = 16'd0;
                    default: c.req_size = FREE_MARK - 16'($urandom_range(0, 1));
                endcase
            end
            else if (sel < 85)
            begin
                c.op = (sel < 65) ? OP_DELETE : OP_LOOKUP;
                if ($urandom_range(0, 4) != 0 && slot_limit(p) > 0)
                begin
                    c.slot = 4'($urandom_range(0, slot_limit(p) - 1));
                end
            end
            else if (sel < 90)
            begin
                c.op = OP_CLEAR_POOL;
            end
            else if (sel < 92)
            begin
                c.op = OP_CLEAR_ALL;
            end
            else if (sel < 95)
            begin
                c.op = 3'($urandom_range(5, 7));
            end
            if (sel < 95)
            begin
                c.pool = p[1:0];
            end
            cmd_queue.push_back(c);
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_SUBPOOLS_USED: m_used = value[2:0];
            CFG_ELEMENT_SIZES: m_sizes = value;
            CFG_SLOT_COUNTS:   m_counts = value[19:0];
            default:           m_spill = value[0];
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [2:0] used, logic [63:0] sizes, logic [19:0] counts,
                              logic spill);
        cfg_write(CFG_SUBPOOLS_USED, 64'(used));
        cfg_write(CFG_ELEMENT_SIZES, sizes);
        cfg_write(CFG_SLOT_COUNTS, 64'(counts));
        cfg_write(CFG_SPILL_ENABLE, 64'(spill));
        @(negedge clk);
    endtask

    // Waits until every queued command has been sent and answered, then lets
    // the back end settle before the configuration may change.
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(pool_step(cur_cmd));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_queue.size() != 0 && !sender_pause)
                begin
                    next_cmd = cmd_queue.pop_front();
                    cur_cmd <= next_cmd;
                    op <= next_cmd.op;
                    req_size <= next_cmd.req_size;
                    pool_sel <= next_cmd.pool;
                    slot_sel <= next_cmd.slot;
                    suppress_report <= next_cmd.quiet;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, counted here once requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (long_hold_req && !hold_taken)
        begin
            hold_left <= LONG_HOLD;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor with a rotating stall pattern that is reloaded now and then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_pat <= 8'hFF;
            pat_age <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transaction, status", 16'(status), 16'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 16'(status), 16'(want.status));
                    if (pool_out !== want.pool)
                        report_mismatch("pool_out", 16'(pool_out), 16'(want.pool));
                    if (slot_out !== want.slot)
                        report_mismatch("slot_out", 16'(slot_out), 16'(want.slot));
                    if (size_out !== want.size)
                        report_mismatch("size_out", size_out, want.size);
                    if (report_full !== want.report)
                        report_mismatch("report_full", 16'(report_full), 16'(want.report));
                end
            end
            pat_age <= pat_age + 6'd1;
            if (pat_age == '0)
            begin
                stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            end
            else
            begin
                stall_pat <= {stall_pat[0], stall_pat[7:1]};
            end
            out_ready <= (hold_left == 0) && stall_pat[0];
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("segregated_block_pool_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] sizes;
        logic [19:0] counts;
        logic [2:0]  used;
        int          lo;
        int          p;
        int          ph;

        for (p = 0; p < POOLS*SLOTS; p++)
        begin
            slot_word[p] = FREE_MARK;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: one subpool of size 0 with no slots.
        queue_cmd(OP_RESERVE, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_RESERVE, 16'd0, 2'd0, 4'd0, 1'b1);
        queue_cmd(OP_RESERVE, 16'd1, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_RESERVE, FREE_MARK, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_DELETE, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_LOOKUP, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_CLEAR_POOL, 16'd0, 2'd3, 4'd0, 1'b0);
        for (p = 5; p < 8; p++)
        begin
            queue_cmd(p[2:0], 16'hFFFF, 2'd3, 4'hF, 1'b1);
        end
        wait_drained();

        set_config(3'd4, 64'hFFFE_0400_0100_0040, {5'd16, 5'd4, 5'd3, 5'd2}, 1'b0);
        queue_cmd(OP_RESERVE, 16'd64, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_RESERVE, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_RESERVE, 16'd10, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_RESERVE, 16'hFFFE, 2'd0, 4'd0, 1'b1);
        queue_cmd(OP_LOOKUP, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_DELETE, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_LOOKUP, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_DELETE, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_DELETE, 16'd0, 2'd0, 4'd5, 1'b0);
        queue_cmd(OP_LOOKUP, 16'd0, 2'd3, 4'd15, 1'b0);
        queue_cmd(OP_CLEAR_POOL, 16'd0, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_RESERVE, FREE_MARK, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_CLEAR_ALL, 16'd0, 2'd0, 4'd0, 1'b0);
        wait_drained();

        // With spilling the third request moves on to subpool 1.
        cfg_write(CFG_SPILL_ENABLE, 64'd1);
        @(negedge clk);
        repeat (3) queue_cmd(OP_RESERVE, 16'd1, 2'd0, 4'd0, 1'b0);
        queue_cmd(OP_CLEAR_ALL, 16'd0, 2'd0, 4'd0, 1'b0);
        wait_drained();

        // Extremes of the registers: counts and the pool number clamp.
        set_config(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF, 1'b1);
        queue_random_cmds(40);
        wait_drained();
        set_config(3'd0, 64'd0, 20'd0, 1'b0);
        queue_random_cmds(10);
        wait_drained();

        for (ph = 0; ph < 8; ph++)
        begin
            used = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(1, 4));
            lo = $urandom_range(0, 40);
            for (p = 0; p < POOLS; p++)
            begin
                sizes[p*16 +: 16] = 16'(lo);
                lo = lo + $urandom_range(0, 300);
                counts[p*5 +: 5] = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                               : 5'($urandom_range(0, 4));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                sizes = {$urandom, $urandom};
            end
            set_config(used, sizes, counts, 1'($urandom_range(0, 1)));
            queue_random_cmds(105);
            if (ph == 2)
            begin
                // Hold results back long enough for the request side to back up.
                @(posedge clk);
                long_hold_req <= 1'b1;
            end
            if (ph == 4)
            begin
                while (cmd_queue.size() > 50)
                begin
                    @(negedge clk);
                end
                @(posedge clk);
                sender_pause <= 1'b1;
                @(negedge clk);
                while (in_valid || expected_results.size() != 0)
                begin
                    @(negedge clk);
                end
                @(posedge clk);
                sender_pause <= 1'b0;
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("segregated_block_pool_allocator: match");
        end
        else
        begin
            $display("segregated_block_pool_allocator: mismatch");
        end
        $finish;
    end

endmodule
